[design/rsfc_pkg.sv]
package rsfc_pkg;

	localparam logic [15:0] CRC_POLY = 16'h1021;

	typedef enum logic [2:0] {
		CFG_HOST_ADDRESS     = 3'd0,
		CFG_ACK_CODE         = 3'd1,
		CFG_EXPECTED_SOURCE  = 3'd2,
		CFG_ALTERNATE_SOURCE = 3'd3,
		CFG_MAX_PAYLOAD      = 3'd4
	} rsfc_cfg_idx_t;

	typedef enum logic [2:0] {
		ERR_NONE   = 3'd0,
		ERR_DEST   = 3'd1,
		ERR_LONG   = 3'd2,
		ERR_SOURCE = 3'd3,
		ERR_ACK    = 3'd4,
		ERR_CRC    = 3'd5
	} rsfc_err_t;

	typedef struct packed {
		logic [7:0] host_address;
		logic [7:0] ack_code;
		logic [7:0] expected_source;
		logic [7:0] alternate_source;
		logic [7:0] max_payload;
	} rsfc_cfg_t;

	typedef struct packed {
		logic [7:0]  dest;
		logic [7:0]  length;
		logic [7:0]  source;
		logic [7:0]  code;
		logic [31:0] payload;
		logic        crc_ok;
	} rsfc_rec_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

[design/rsfc_front.sv]
module rsfc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_accept,
	input  logic [7:0]        data_byte,
	input  logic              frame_start,
	output logic              rec_push,
	output rsfc_pkg::rsfc_rec_t rec
);
	import rsfc_pkg::*;

	logic [8:0]  pos_q;
	logic [15:0] crc_q;
	logic [7:0]  dest_q;
	logic [7:0]  len_q;
	logic [7:0]  src_q;
	logic [7:0]  code_q;
	logic [31:0] payload_q;
	logic [7:0]  crc_lo_q;

	logic [8:0]  pos_eff;
	logic [7:0]  len_eff;
	logic [15:0] crc_eff;
	logic [31:0] payload_eff;
	logic [8:0]  len_plus4;
	logic        active;
	logic        in_body;
	logic        is_crc_lo;
	logic        is_last;

	always_comb begin
		pos_eff     = frame_start ? 9'd0 : pos_q;
		len_eff     = frame_start ? 8'd0 : len_q;
		crc_eff     = frame_start ? 16'd0 : crc_q;
		payload_eff = frame_start ? 32'd0 : payload_q;
		active      = frame_start || (pos_q != 9'd0);
		len_plus4   = {1'b0, len_eff} + 9'd4;
		in_body     = (pos_eff < len_plus4) || (pos_eff < 9'd4);
		is_crc_lo   = !in_body && (pos_eff == len_plus4);
		is_last     = !in_body && !is_crc_lo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 9'd0;
		end else if (in_accept && active) begin
			if (is_last) begin
				pos_q <= 9'd0;
			end else begin
				pos_q <= pos_eff + 9'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && active) begin
			if (frame_start) begin
				len_q     <= 8'd0;
				payload_q <= 32'd0;
			end
			if (in_body) begin
				crc_q <= crc16_byte(crc_eff, data_byte);
				if (pos_eff == 9'd0) begin
					dest_q <= data_byte;
				end else if (pos_eff == 9'd1) begin
					len_q <= data_byte;
				end else if (pos_eff == 9'd2) begin
					src_q <= data_byte;
				end else if (pos_eff == 9'd3) begin
					code_q <= data_byte;
				end else if (pos_eff[8:2] == 7'd1) begin
					case (pos_eff[1:0])
						2'd0: payload_q <= {payload_eff[31:8], data_byte};
						2'd1: payload_q <= {payload_eff[31:16], data_byte, payload_eff[7:0]};
						2'd2: payload_q <= {payload_eff[31:24], data_byte, payload_eff[15:0]};
						default: payload_q <= {data_byte, payload_eff[23:0]};
					endcase
				end
			end else if (is_crc_lo) begin
				crc_lo_q <= data_byte;
			end
		end
	end

	always_comb begin
		rec_push    = in_accept && active && is_last;
		rec.dest    = dest_q;
		rec.length  = len_q;
		rec.source  = src_q;
		rec.code    = code_q;
		rec.payload = payload_q;
		rec.crc_ok  = ({data_byte, crc_lo_q} == crc_q);
	end

endmodule

[design/rsfc_queue.sv]
module rsfc_queue #(
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  rsfc_pkg::rsfc_rec_t wr_rec,
	output logic                q_full,
	input  logic                rd_en,
	output rsfc_pkg::rsfc_rec_t rd_rec,
	output logic                q_empty
);
	import rsfc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rsfc_rec_t       mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_wr;
	logic            do_rd;

	assign q_full  = (count_q == CW'(DEPTH));
	assign q_empty = (count_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_rec  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count exceeds depth");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !q_full)
		else $error("item pushed into full queue");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("queue count did not follow a write");

endmodule

[design/rsfc_back.sv]
module rsfc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  rsfc_pkg::rsfc_cfg_t cfg,
	input  logic                q_empty,
	input  rsfc_pkg::rsfc_rec_t q_rec,
	output logic                q_pop,
	input  logic                pop,
	output logic                empty,
	output logic                frame_ok,
	output logic [2:0]          error_code,
	output logic [7:0]          source_address,
	output logic [7:0]          payload_length,
	output logic [31:0]         payload_head
);
	import rsfc_pkg::*;

	logic      out_valid_q;
	rsfc_err_t err;

	always_comb begin
		if (q_rec.dest != cfg.host_address) begin
			err = ERR_DEST;
		end else if (q_rec.length > cfg.max_payload) begin
			err = ERR_LONG;
		end else if (q_rec.source != cfg.expected_source
				&& q_rec.source != cfg.alternate_source) begin
			err = ERR_SOURCE;
		end else if (q_rec.code != cfg.ack_code) begin
			err = ERR_ACK;
		end else if (!q_rec.crc_ok) begin
			err = ERR_CRC;
		end else begin
			err = ERR_NONE;
		end
	end

	assign q_pop = !q_empty && (!out_valid_q || pop);
	assign empty = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			frame_ok       <= (err == ERR_NONE);
			error_code     <= err;
			source_address <= q_rec.source;
			payload_length <= q_rec.length;
			payload_head   <= q_rec.payload;
		end
	end

endmodule

[design/rs485_response_frame_checker_unit.sv]
// Checks RS-485 response frames one received byte per clock: destination, length, source,
// code, payload and a CRC-16/XMODEM sent low byte first. A new byte is taken every cycle
// while full is low; full rises when the result queue (QUEUE_DEPTH entries) is full, and for
// a depth above one the output register then holds a result too. The verdict of a frame
// appears on the result ports at the clock edge after the one that takes its last CRC byte,
// when the output register is free, as one item with frame_ok, the first failing check in
// error_code, and the source, length and first four payload bytes.
// Configuration writes are taken every cycle (cfg_ready is always high).
module rs485_response_frame_checker_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        frame_start,
	output logic        empty,
	input  logic        pop,
	output logic        frame_ok,
	output logic [2:0]  error_code,
	output logic [7:0]  source_address,
	output logic [7:0]  payload_length,
	output logic [31:0] payload_head,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import rsfc_pkg::*;

	rsfc_cfg_t cfg_q;
	rsfc_rec_t front_rec;
	rsfc_rec_t head_rec;
	logic      in_accept;
	logic      rec_push;
	logic      q_empty;
	logic      q_pop;

	assign cfg_ready = 1'b1;
	assign in_accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.host_address     <= 8'd0;
			cfg_q.ack_code         <= 8'd0;
			cfg_q.expected_source  <= 8'd0;
			cfg_q.alternate_source <= 8'd255;
			cfg_q.max_payload      <= 8'd10;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_HOST_ADDRESS:     cfg_q.host_address     <= cfg_data;
				CFG_ACK_CODE:         cfg_q.ack_code         <= cfg_data;
				CFG_EXPECTED_SOURCE:  cfg_q.expected_source  <= cfg_data;
				CFG_ALTERNATE_SOURCE: cfg_q.alternate_source <= cfg_data;
				CFG_MAX_PAYLOAD:      cfg_q.max_payload      <= cfg_data;
				default: ;
			endcase
		end
	end

	rsfc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_accept   (in_accept),
		.data_byte   (data_byte),
		.frame_start (frame_start),
		.rec_push    (rec_push),
		.rec         (front_rec)
	);

	rsfc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (rec_push),
		.wr_rec  (front_rec),
		.q_full  (full),
		.rd_en   (q_pop),
		.rd_rec  (head_rec),
		.q_empty (q_empty)
	);

	rsfc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.q_empty        (q_empty),
		.q_rec          (head_rec),
		.q_pop          (q_pop),
		.pop            (pop),
		.empty          (empty),
		.frame_ok       (frame_ok),
		.error_code     (error_code),
		.source_address (source_address),
		.payload_length (payload_length),
		.payload_head   (payload_head)
	);

endmodule

[verif/rs485_response_frame_checker_unit_test.sv]
module rs485_response_frame_checker_unit_test;
	import rsfc_pkg::*;

	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int QUIET_LIMIT   = 3000;

	typedef struct packed {
		logic        ok;
		rsfc_err_t   err;
		logic [7:0]  src;
		logic [7:0]  len;
		logic [31:0] head;
	} verdict_t;

	typedef struct packed {
		logic [7:0] b;
		logic       s;
		logic       typed;
		verdict_t   v;
	} script_row_t;

	localparam verdict_t NO_V = '0;
	localparam verdict_t V_OK = '{1'b1, ERR_NONE, 8'h00, 8'h00, 32'h0};
	localparam verdict_t V_LONG = '{1'b0, ERR_LONG, 8'hFF, 8'h05, 32'h7F0180FF};
	localparam verdict_t V_DEST = '{1'b0, ERR_DEST, 8'h00, 8'h00, 32'h0};
	localparam verdict_t V_CRC = '{1'b0, ERR_CRC, 8'h00, 8'h00, 32'h0};

	// runs with max_payload = 4, other registers at reset values
	localparam script_row_t SCRIPT [31] = '{
		'{8'h5A, 1'b0, 1'b0, NO_V},	// stray byte while idle
		'{8'h00, 1'b1, 1'b0, NO_V},	// partial frame, dropped by restart
		'{8'h00, 1'b1, 1'b0, NO_V},	// zero length, all zero, good crc
		'{8'h00, 1'b0, 1'b0, NO_V},
		'{8'h00, 1'b0, 1'b0, NO_V},
		'{8'h00, 1'b0, 1'b0, NO_V},
		'{8'h00, 1'b0, 1'b0, NO_V},
		'{8'h00, 1'b0, 1'b1, V_OK},
		'{8'h00, 1'b1, 1'b0, NO_V},	// length 5 over limit, long payload
		'{8'h05, 1'b0, 1'b0, NO_V},
		'{8'hFF, 1'b0, 1'b0, NO_V},
		'{8'h00, 1'b0, 1'b0, NO_V},
		'{8'hFF, 1'b0, 1'b0, NO_V},
		'{8'h80, 1'b0, 1'b0, NO_V},
		'{8'h01, 1'b0, 1'b0, NO_V},
		'{8'h7F, 1'b0, 1'b0, NO_V},
		'{8'hAA, 1'b0, 1'b0, NO_V},
		'{8'h12, 1'b0, 1'b0, NO_V},
		'{8'h34, 1'b0, 1'b1, V_LONG},
		'{8'hFF, 1'b1, 1'b0, NO_V},	// wrong destination
		'{8'h00, 1'b0, 1'b0, NO_V},
		'{8'h00, 1'b0, 1'b0, NO_V},
		'{8'h00, 1'b0, 1'b0, NO_V},
		'{8'hFF, 1'b0, 1'b0, NO_V},
		'{8'hFF, 1'b0, 1'b1, V_DEST},
		'{8'h00, 1'b1, 1'b0, NO_V},	// crc mismatch
		'{8'h00, 1'b0, 1'b0, NO_V},
		'{8'h00, 1'b0, 1'b0, NO_V},
		'{8'h00, 1'b0, 1'b0, NO_V},
		'{8'h00, 1'b0, 1'b0, NO_V},
		'{8'h80, 1'b0, 1'b1, V_CRC}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  data_byte = 8'h00;
	logic        frame_start = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic        frame_ok;
	logic [2:0]  error_code;
	logic [7:0]  source_address;
	logic [7:0]  payload_length;
	logic [31:0] payload_head;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = CFG_HOST_ADDRESS;
	logic [7:0]  cfg_data = 8'h00;

	rs485_response_frame_checker_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.frame_start(frame_start),
		.empty(empty),
		.pop(pop),
		.frame_ok(frame_ok),
		.error_code(error_code),
		.source_address(source_address),
		.payload_length(payload_length),
		.payload_head(payload_head),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	rsfc_cfg_t   regs_now = '{8'h00, 8'h00, 8'h00, 8'hFF, 8'd10};
	logic [8:0]  fpos = '0;
	logic [15:0] f_crc = '0;
	logic [7:0]  f_dest = '0, f_len = '0, f_src = '0, f_code = '0, f_crc_lo = '0;
	logic [31:0] f_head = '0;

	verdict_t    verdicts_due[$];
	logic [8:0]  frame_buf[$];
	int          send_idle = 0;
	int          recv_idle = 30;
	bit          hold_req = 1'b0;
	int          fails = 0;
	int          quiet = 0;

	function automatic logic [15:0] xmodem_next(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			r = {r[14:0], 1'b0} ^ (r[15] ? CRC_POLY : 16'h0000);
		end
		return r;
	endfunction

	task automatic follow_frame(input logic [7:0] b, input logic s, output logic got,
			output verdict_t v);
		logic [15:0] rx;
		got = 1'b0;
		v = '0;
		if (s) begin
			fpos = '0;
			f_crc = '0;
			f_dest = '0;
			f_len = '0;
			f_src = '0;
			f_code = '0;
			f_head = '0;
			f_crc_lo = '0;
		end else if (fpos == 9'd0) begin
			return;
		end
		if (fpos < {1'b0, f_len} + 9'd4 || fpos < 9'd4) begin
			f_crc = xmodem_next(f_crc, b);
			if (fpos == 9'd0) f_dest = b;
			else if (fpos == 9'd1) f_len = b;
			else if (fpos == 9'd2) f_src = b;
			else if (fpos == 9'd3) f_code = b;
			else if (fpos < 9'd8) f_head[{fpos[1:0], 3'b000} +: 8] = b;
			fpos = fpos + 9'd1;
		end else if (fpos == {1'b0, f_len} + 9'd4) begin
			f_crc_lo = b;
			fpos = fpos + 9'd1;
		end else begin
			rx = {b, f_crc_lo};
			if (f_dest != regs_now.host_address) v.err = ERR_DEST;
			else if (f_len > regs_now.max_payload) v.err = ERR_LONG;
			else if (f_src != regs_now.expected_source && f_src != regs_now.alternate_source)
				v.err = ERR_SOURCE;
			else if (f_code != regs_now.ack_code) v.err = ERR_ACK;
			else if (rx != f_crc) v.err = ERR_CRC;
			else v.err = ERR_NONE;
			v.ok = (v.err == ERR_NONE);
			v.src = f_src;
			v.len = f_len;
			v.head = f_head;
			got = 1'b1;
			fpos = '0;
		end
	endtask

	// offer one byte, wait for it to be taken, then update the expected verdicts
	task automatic feed(input logic [7:0] b, input logic s, input logic use_typed,
			input verdict_t typed_v);
		logic got;
		verdict_t v;
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		frame_start <= s;
		@(posedge clk);
		while (full) @(posedge clk);
		follow_frame(b, s, got, v);
		if (use_typed) verdicts_due.push_back(typed_v);
		else if (got) verdicts_due.push_back(v);
	endtask

	task automatic write_reg(input rsfc_cfg_idx_t idx, input logic [7:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_HOST_ADDRESS:     regs_now.host_address = d;
			CFG_ACK_CODE:         regs_now.ack_code = d;
			CFG_EXPECTED_SOURCE:  regs_now.expected_source = d;
			CFG_ALTERNATE_SOURCE: regs_now.alternate_source = d;
			CFG_MAX_PAYLOAD:      regs_now.max_payload = d;
			default: ;
		endcase
	endtask

	task automatic build_frame();
		logic [7:0]  hd, hl, hs, hc;
		logic [15:0] crc;
		int          lim, r;
		frame_buf.delete();
		lim = int'(regs_now.max_payload);
		hd = ($urandom_range(99) < 90) ? regs_now.host_address : 8'($urandom);
		r = $urandom_range(99);
		if (r < 8 && lim < 255) hl = 8'($urandom_range(lim + 1, (lim + 4 > 255) ? 255 : lim + 4));
		else if (r < 10) hl = 8'($urandom_range(0, lim));
		else hl = 8'($urandom_range(0, (lim < 8) ? lim : 8));
		r = $urandom_range(99);
		if (r < 45) hs = regs_now.expected_source;
		else if (r < 85) hs = regs_now.alternate_source;
		else hs = 8'($urandom);
		hc = ($urandom_range(99) < 90) ? regs_now.ack_code : 8'($urandom);
		frame_buf.push_back({1'b1, hd});
		frame_buf.push_back({1'b0, hl});
		frame_buf.push_back({1'b0, hs});
		frame_buf.push_back({1'b0, hc});
		for (int i = 0; i < hl; i++) frame_buf.push_back({1'b0, 8'($urandom)});
		crc = '0;
		foreach (frame_buf[i]) crc = xmodem_next(crc, frame_buf[i][7:0]);
		if ($urandom_range(99) < 12) crc = crc ^ 16'($urandom_range(1, 65535));
		frame_buf.push_back({1'b0, crc[7:0]});
		frame_buf.push_back({1'b0, crc[15:8]});
	endtask

	task automatic send_buf(input int n);
		logic [8:0] e;
		repeat (n) begin
			e = frame_buf.pop_front();
			feed(e[7:0], e[8], 1'b0, NO_V);
		end
	endtask

	task automatic run_phase(input rsfc_cfg_t c, input int s_idle, input int r_idle,
			input int budget, input bit hold);
		int sent;
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(CFG_HOST_ADDRESS, c.host_address);
		write_reg(CFG_ACK_CODE, c.ack_code);
		write_reg(CFG_EXPECTED_SOURCE, c.expected_source);
		write_reg(CFG_ALTERNATE_SOURCE, c.alternate_source);
		write_reg(CFG_MAX_PAYLOAD, c.max_payload);
		cfg_valid <= 1'b0;
		send_idle = s_idle;
		recv_idle = r_idle;
		if (hold) hold_req = 1'b1;
		// finish the frame left open before the register change
		send_buf(frame_buf.size());
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(99) < 5) begin
				repeat ($urandom_range(1, 3)) feed(8'($urandom), 1'b0, 1'b0, NO_V);
			end
			build_frame();
			if ($urandom_range(99) < 8)
				while (frame_buf.size() > 1 && $urandom_range(3) != 0) void'(frame_buf.pop_back());
			sent += frame_buf.size();
			send_buf(frame_buf.size());
		end
		build_frame();
		send_buf($urandom_range(1, frame_buf.size() - 1));
		push <= 1'b0;
	endtask

	initial begin
		rsfc_cfg_t c;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_reg(CFG_MAX_PAYLOAD, 8'd4);
		cfg_valid <= 1'b0;
		foreach (SCRIPT[i]) feed(SCRIPT[i].b, SCRIPT[i].s, SCRIPT[i].typed, SCRIPT[i].v);
		push <= 1'b0;
		run_phase(rsfc_cfg_t'{8'h5A, 8'h06, 8'h21, 8'h22, 8'd8}, 16, 79, 125, 1'b0);
		run_phase(rsfc_cfg_t'{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'd255}, 79, 16, 125, 1'b0);
		run_phase(rsfc_cfg_t'{8'h00, 8'h00, 8'h00, 8'hFF, 8'd0}, 0, 0, 125, 1'b0);
		c.host_address = 8'($urandom);
		c.ack_code = 8'($urandom);
		c.expected_source = 8'($urandom);
		c.alternate_source = 8'($urandom);
		c.max_payload = 8'($urandom_range(0, 12));
		run_phase(c, 0, 0, 125, 1'b1);
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fails == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// result side, with a long hold-off on request
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			pop <= ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic check_field(input string fname, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, fname, want, got);
			fails++;
		end
	endtask

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && pop && !empty) begin
			if (verdicts_due.size() == 0) begin
				$display("%0t: result with none expected, expected nothing actual err %0h",
					$time, error_code);
				fails++;
			end else begin
				want = verdicts_due.pop_front();
				check_field("frame_ok", 32'(want.ok), 32'(frame_ok));
				check_field("error_code", 32'(want.err), 32'(error_code));
				check_field("source_address", 32'(want.src), 32'(source_address));
				check_field("payload_length", 32'(want.len), 32'(payload_length));
				check_field("payload_head", want.head, payload_head);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
		if (quiet == QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

endmodule
